>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified concurrent assertion shorthands for the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DSLOM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dslom checker: same-cycle property failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DSLOM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dslom checker: next-cycle property failed");

`endif

>>> rtl/dslom_pkg.sv
// ----------------------------------------------------------------------------
// Dust sensor occupancy meter package
// Field widths, fixed-point constants and shared types.
// ----------------------------------------------------------------------------
package dslom_pkg;

  // Field widths
  localparam int unsigned WIN_W  = 16;  // window length and tick counter
  localparam int unsigned LOW_W  = 16;  // low tick counter
  localparam int unsigned PCT_W  = 23;  // low_percent field
  localparam int unsigned CNT_W  = 30;  // particle_count field

  // Horner evaluation widths (percentage in Q16, at most 100.0)
  localparam int unsigned P16_W  = 23;
  localparam int unsigned T1_W   = 30;
  localparam int unsigned T2_W   = 37;
  localparam int unsigned T3_W   = 43;
  localparam int unsigned PROD_W = T2_W + P16_W;

  // Final scale 100 * 256 = 25 * 2^10
  localparam int unsigned SCALE_SHIFT = 10;
  localparam int unsigned T3Q_W       = T3_W - SCALE_SHIFT;
  localparam logic [WIN_W-1:0] SCALE_DIV = 16'd25;

  // Horner offsets, polynomial scaled by 100, in Q16
  localparam logic [T1_W-1:0] C0_T1 = T1_W'(380) << 16;
  localparam logic [T2_W-1:0] C0_T2 = T2_W'(52000) << 16;
  localparam logic [T3_W-1:0] C0_T3 = T3_W'(62) << 16;

  // Saturation limits and reset values
  localparam logic [PCT_W-1:0] PCT_MAX      = '1;
  localparam logic [CNT_W-1:0] CNT_MAX      = '1;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd30000;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

endpackage

>>> rtl/dslom_in_if.sv
// ----------------------------------------------------------------------------
// Tick channel
// Valid/ready channel carrying one millisecond tick with the pin level.
// ----------------------------------------------------------------------------
interface dslom_in_if;
  logic valid;
  logic ready;
  logic pin_low;

  modport source (output valid, output pin_low, input ready);
  modport sink   (input valid, input pin_low, output ready);
endinterface

>>> rtl/dslom_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the per-window occupancy result.
// ----------------------------------------------------------------------------
interface dslom_out_if import dslom_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [LOW_W-1:0] low_ms;
  logic [PCT_W-1:0] low_percent;
  logic [CNT_W-1:0] particle_count;

  modport source (output valid, output low_ms, output low_percent,
                  output particle_count, input ready);
  modport sink   (input valid, input low_ms, input low_percent,
                  input particle_count, output ready);
endinterface

>>> rtl/dslom_serial_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle, dividend fed MSB first.
// ----------------------------------------------------------------------------
module dslom_serial_div import dslom_pkg::*; #(
  parameter int unsigned DVD_W = 39,
  parameter int unsigned DSR_W = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DVD_W-1:0]             dividend_i,  // left aligned
  input  logic [DSR_W-1:0]             divisor_i,
  input  logic [$clog2(DVD_W+1)-1:0]   nbits_i,
  output ser_stat_t                    stat_o,
  output logic [DVD_W-1:0]             quotient_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q;
  logic [DVD_W-1:0] quo_q;
  logic [DSR_W-1:0] rem_q;
  logic [DSR_W-1:0] dsr_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= nbits_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Shift one dividend bit into the partial remainder per cycle
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign stat_o     = '{busy: busy_q, done: done_q};
  assign quotient_o = quo_q;

endmodule

>>> rtl/dslom_serial_mult.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-add multiply, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module dslom_serial_mult import dslom_pkg::*; #(
  parameter int unsigned A_W = 37,
  parameter int unsigned B_W = 23
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output ser_stat_t          stat_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int unsigned CW = $clog2(B_W + 1);

  logic [A_W-1:0] mcand_q;
  logic [A_W-1:0] hi_q;
  logic [B_W-1:0] lo_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic           done_q;
  logic [A_W:0]   sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Add when the multiplier bit is set, then shift the pair right
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      mcand_q <= a_i;
      hi_q    <= '0;
      lo_q    <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[A_W:1];
      lo_q <= {sum[0], lo_q[B_W-1:1]};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign prod_o = {hi_q, lo_q};

endmodule

>>> rtl/dust_sensor_low_occupancy_meter.sv
// ----------------------------------------------------------------------------
// Dust sensor low-pulse occupancy meter
// Counts low ticks over a programmable window and reports occupancy and
// particle concentration at the end of each window.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch_i  : one transfer per millisecond tick; pin_low is 1 when the sensor
//              output is low during that tick.
//   out_ch_o : one transfer per finished window with low_ms, low_percent
//              (Q.PERCENT_FRAC_BITS) and particle_count (Q.8, saturating).
//   cfg_we_i / cfg_wdata_i : write window_ms (ticks); 0 acts as 1. Write only
//              while the block is idle.
// Sequencing:
//   A tick that does not close the window only updates the counters, and
//   in_ch_i.ready stays high for the next one. The closing tick runs a
//   bit-serial sequence: a restoring divide of max(23+F, 33) steps for the
//   percentage, two 23-step shift-add multiplies for the Horner terms and a
//   33-step divide by 25 for the final scale, then loads the result
//   register; in_ch_i.ready stays low during that sequence.
// Reset: rst_ni clears the counters, the sequencer and the output valid, and
//   sets window_ms to 30000.
// Stall: the result sits in an output register; ticks are taken while it
//   waits. A following window end holds in its last state until the old
//   result is transferred.
// ----------------------------------------------------------------------------
module dust_sensor_low_occupancy_meter import dslom_pkg::*; #(
  parameter int unsigned PERCENT_FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WIN_W-1:0]  cfg_wdata_i,
  dslom_in_if.sink          in_ch_i,
  dslom_out_if.source       out_ch_o
);

  localparam int unsigned FB     = PERCENT_FRAC_BITS;
  localparam int unsigned NUM_W  = PCT_W + FB;              // lows*100 << FB
  localparam int unsigned DIV_W  = (NUM_W > T3Q_W) ? NUM_W : T3Q_W;
  localparam int unsigned DCNT_W = $clog2(DIV_W + 1);
  localparam int unsigned PCTF_W = 7 + FB;                   // holds 100 << FB
  localparam int unsigned EXT_W  = PCTF_W + PCT_W;
  localparam int unsigned P16X_W = PCTF_W + 16;

  localparam logic [DIV_W-1:0] FULL_PCT    = DIV_W'(100) << FB;
  localparam logic [EXT_W-1:0] PCT_MAX_EXT = EXT_W'(PCT_MAX);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIV_PCT = 3'd1;
  localparam logic [2:0] ST_POLY    = 3'd2;
  localparam logic [2:0] ST_MUL1    = 3'd3;
  localparam logic [2:0] ST_MUL2    = 3'd4;
  localparam logic [2:0] ST_DIV_CNT = 3'd5;
  localparam logic [2:0] ST_OUT     = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [WIN_W-1:0]  window_q;
  logic [WIN_W-1:0]  tick_q;
  logic [LOW_W-1:0]  low_q;
  logic [LOW_W-1:0]  lows_q;
  logic [P16_W-1:0]  p16_q;
  logic [PCT_W-1:0]  pct_res_q;
  logic [CNT_W-1:0]  cnt_res_q;

  logic              out_valid_q;
  logic [LOW_W-1:0]  out_low_q;
  logic [PCT_W-1:0]  out_pct_q;
  logic [CNT_W-1:0]  out_cnt_q;

  // Tick bookkeeping
  logic              in_fire;
  logic [WIN_W:0]    ticks;
  logic [LOW_W-1:0]  lows;
  logic [WIN_W-1:0]  win_eff;
  logic              win_end;
  logic [PCT_W-1:0]  lows_x100;
  logic              out_free;

  // Serial units
  logic              div_start;
  logic [DIV_W-1:0]  div_dvd;
  logic [WIN_W-1:0]  div_dsr;
  logic [DCNT_W-1:0] div_nbits;
  ser_stat_t         div_stat;
  logic [DIV_W-1:0]  div_quo;

  logic              mul_start;
  logic [T2_W-1:0]   mul_a;
  ser_stat_t         mul_stat;
  logic [PROD_W-1:0] mul_prod;

  // Datapath between serial steps
  logic [DIV_W-1:0]  pct_sat;
  logic [PCTF_W-1:0] pct_n;
  logic [EXT_W-1:0]  pct_ext;
  logic [P16X_W-1:0] p16_wide;
  logic [T1_W-1:0]   t1;
  logic [T2_W-1:0]   t2;
  logic [T3_W-1:0]   t3;
  logic [T3Q_W-1:0]  t3q;
  logic [T3Q_W-1:0]  cnt_raw;

  assign in_fire  = in_ch_i.valid && in_ch_i.ready;
  assign ticks    = {1'b0, tick_q} + (WIN_W+1)'(1);
  assign lows     = low_q + LOW_W'(in_ch_i.pin_low);
  assign win_eff  = (window_q == '0) ? WIN_W'(1) : window_q;
  // A window shrunk below the ticks already seen also ends here
  assign win_end  = (ticks >= {1'b0, win_eff});
  // lows * 100 as 64 + 32 + 4
  assign lows_x100 = (PCT_W'(lows) << 6) + (PCT_W'(lows) << 5) + (PCT_W'(lows) << 2);
  assign out_free = !out_valid_q || out_ch_o.ready;

  // Percentage: clamp at 100.0, then rescale to Q16 for the polynomial
  assign pct_sat  = (div_quo > FULL_PCT) ? FULL_PCT : div_quo;
  assign pct_n    = pct_sat[PCTF_W-1:0];
  assign pct_ext  = EXT_W'(pct_n);
  assign p16_wide = {pct_n, 16'b0} >> FB;

  // Horner terms; 110*p as 128p - 16p - 2p
  assign t1  = (T1_W'(p16_q) << 7) - (T1_W'(p16_q) << 4) - (T1_W'(p16_q) << 1) + C0_T1;
  assign t2  = mul_prod[T2_W+15:16] + C0_T2;
  assign t3  = mul_prod[T3_W+15:16] + C0_T3;
  assign t3q = t3[T3_W-1:SCALE_SHIFT];
  assign cnt_raw = div_quo[T3Q_W-1:0];

  // Start requests to the serial units
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = win_eff;
    div_nbits = DCNT_W'(DIV_W);
    mul_start = 1'b0;
    mul_a     = T2_W'(t1);
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && win_end) begin
          div_start = !div_stat.busy;
          div_dvd   = DIV_W'({lows_x100, {FB{1'b0}}});
        end
      end
      ST_POLY: begin
        mul_start = !mul_stat.busy;
      end
      ST_MUL1: begin
        mul_start = mul_stat.done;
        mul_a     = t2;
      end
      ST_MUL2: begin
        div_start = mul_stat.done;
        div_dvd   = DIV_W'(t3q) << (DIV_W - T3Q_W);
        div_dsr   = SCALE_DIV;
        div_nbits = DCNT_W'(T3Q_W);
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_fire && win_end) state_d = ST_DIV_PCT;
      ST_DIV_PCT: if (div_stat.done) state_d = ST_POLY;
      ST_POLY:    state_d = ST_MUL1;
      ST_MUL1:    if (mul_stat.done) state_d = ST_MUL2;
      ST_MUL2:    if (mul_stat.done) state_d = ST_DIV_CNT;
      ST_DIV_CNT: if (div_stat.done) state_d = ST_OUT;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= WINDOW_RESET;
      tick_q      <= '0;
      low_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      // Advance the counters per tick; clear them on the closing tick
      if (in_fire) begin
        if (win_end) begin
          tick_q <= '0;
          low_q  <= '0;
        end else begin
          tick_q <= ticks[WIN_W-1:0];
          low_q  <= lows;
        end
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Intermediate and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_fire && win_end) begin
      lows_q <= lows;
    end
    if (state_q == ST_DIV_PCT && div_stat.done) begin
      p16_q     <= p16_wide[P16_W-1:0];
      pct_res_q <= (pct_ext > PCT_MAX_EXT) ? PCT_MAX : pct_ext[PCT_W-1:0];
    end
    if (state_q == ST_DIV_CNT && div_stat.done) begin
      cnt_res_q <= (cnt_raw > T3Q_W'(CNT_MAX)) ? CNT_MAX : cnt_raw[CNT_W-1:0];
    end
    if (state_q == ST_OUT && out_free) begin
      out_low_q <= lows_q;
      out_pct_q <= pct_res_q;
      out_cnt_q <= cnt_res_q;
    end
  end

  dslom_serial_div #(
    .DVD_W (DIV_W),
    .DSR_W (WIN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .nbits_i    (div_nbits),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  dslom_serial_mult #(
    .A_W (T2_W),
    .B_W (P16_W)
  ) u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (p16_q),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  assign in_ch_i.ready           = (state_q == ST_IDLE);
  assign out_ch_o.valid          = out_valid_q;
  assign out_ch_o.low_ms         = out_low_q;
  assign out_ch_o.low_percent    = out_pct_q;
  assign out_ch_o.particle_count = out_cnt_q;

endmodule

>>> rtl/dslom_checker.sv
// ----------------------------------------------------------------------------
// Occupancy meter port checker
// Port-level properties of the occupancy meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dslom_checker import dslom_pkg::*; #(
  parameter int unsigned PERCENT_FRAC_BITS = 16
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [LOW_W-1:0] low_ms_i,
  input logic [PCT_W-1:0] low_percent_i,
  input logic [CNT_W-1:0] particle_count_i
);

  localparam logic [63:0] FULL_PCT  = 64'd100 << PERCENT_FRAC_BITS;
  localparam logic [63:0] PCT_LIMIT = (FULL_PCT > 64'h7F_FFFF) ? 64'h7F_FFFF : FULL_PCT;
  // Concentration at 0 percent and an upper bound just above its value at 100 percent, Q.8
  localparam logic [CNT_W-1:0] CNT_LO = 30'd158;
  localparam logic [CNT_W-1:0] CNT_HI = 30'd304640160;

  logic                         out_stall;
  logic [LOW_W+PCT_W+CNT_W-1:0] out_payload;
  logic                         cnt_in_range;

  assign out_stall    = out_valid_i && !out_ready_i;
  assign out_payload  = {low_ms_i, low_percent_i, particle_count_i};
  assign cnt_in_range = (particle_count_i >= CNT_LO) && (particle_count_i <= CNT_HI);

  // Hold a stalled result
  `DSLOM_ASSERT_NXT(a_out_hold, out_stall, out_valid_i && $stable(out_payload))
  // Percentage never exceeds 100 percent or the field
  `DSLOM_ASSERT_IMP(a_pct_limit, out_valid_i, 64'(low_percent_i) <= PCT_LIMIT)
  // Concentration stays within the polynomial's range over 0..100 percent
  `DSLOM_ASSERT_IMP(a_cnt_range, out_valid_i, cnt_in_range)
  // A new result only follows a cycle in which ticks were held off
  `DSLOM_ASSERT_IMP(a_out_after_busy, $rose(out_valid_i), !$past(in_ready_i))

endmodule

bind dust_sensor_low_occupancy_meter dslom_checker #(
  .PERCENT_FRAC_BITS (PERCENT_FRAC_BITS)
) u_dslom_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_ch_i.ready),
  .out_valid_i      (out_ch_o.valid),
  .out_ready_i      (out_ch_o.ready),
  .low_ms_i         (out_ch_o.low_ms),
  .low_percent_i    (out_ch_o.low_percent),
  .particle_count_i (out_ch_o.particle_count)
);

>>> tb/tb_dust_sensor_low_occupancy_meter.sv
// ----------------------------------------------------------------------------
// Dust sensor low-pulse occupancy meter testbench
// Drives millisecond ticks with random pin levels and window lengths into the
// meter, predicts each window result in a scoreboard and checks every result
// transfer field by field, with random idling on both channels and one long
// result stall that backs the meter up into its tick input.
// ----------------------------------------------------------------------------
module tb_dust_sensor_low_occupancy_meter;
  import dslom_pkg::*;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned RAND_ITEMS  = 1200;
  localparam int unsigned MIN_WINDOWS = 40;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 200;  // wait for a stray result after the drain
  localparam int unsigned IDLE_GAP    = 8;    // idle gap before a window write
  localparam int unsigned LIMIT       = 1000000;

  // One finished window as seen on the result channel
  typedef struct packed {
    logic [LOW_W-1:0] low_ms;
    logic [PCT_W-1:0] low_percent;
    logic [CNT_W-1:0] particle_count;
  } window_result_t;

  // Tracks the window counters and holds the results still owed by the meter
  class occupancy_scoreboard;
    logic [WIN_W-1:0] window;
    logic [WIN_W-1:0] tick_count;
    logic [LOW_W-1:0] low_count;
    window_result_t   owed[$];
    int unsigned      errors;
    int unsigned      windows_seen;

    function new();
      window       = WINDOW_RESET;
      tick_count   = '0;
      low_count    = '0;
      errors       = 0;
      windows_seen = 0;
    endfunction

    function void set_window(logic [WIN_W-1:0] value);
      window = value;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // Low percentage and Horner evaluation of the concentration polynomial
    function window_result_t close_window(logic [16:0] lows, logic [16:0] win);
      logic [63:0] full, pct, p16, t1, t2, t3, dens;
      window_result_t r;
      full = 64'd100 << FRAC_BITS;
      pct  = ((64'(lows) * 64'd100) << FRAC_BITS) / 64'(win);
      // clamp a shrunk window at one hundred percent before the polynomial
      if (pct > full) pct = full;
      if (FRAC_BITS >= 16) begin
        p16 = pct >> (FRAC_BITS - 16);
      end else begin
        p16 = pct << (16 - FRAC_BITS);
      end
      t1   = 64'd110 * p16 + (64'd380 << 16);
      t2   = ((t1 * p16) >> 16) + (64'd52000 << 16);
      t3   = ((t2 * p16) >> 16) + (64'd62 << 16);
      dens = t3 / 64'd25600;
      if (dens > 64'(CNT_MAX)) dens = 64'(CNT_MAX);
      r.low_ms         = lows[LOW_W-1:0];
      r.low_percent    = (pct > 64'(PCT_MAX)) ? PCT_MAX : pct[PCT_W-1:0];
      r.particle_count = dens[CNT_W-1:0];
      return r;
    endfunction

    // Account for one accepted tick; queue a result when it closes the window
    function void take_tick(logic pin);
      logic [16:0] win, ticks, lows;
      win   = (window == '0) ? 17'd1 : {1'b0, window};
      ticks = {1'b0, tick_count} + 17'd1;
      lows  = {1'b0, low_count} + 17'(pin);
      if (ticks < win) begin
        tick_count = ticks[WIN_W-1:0];
        low_count  = lows[LOW_W-1:0];
      end else begin
        owed.push_back(close_window(lows, win));
        tick_count = '0;
        low_count  = '0;
      end
    endfunction

    function void match_result(window_result_t got);
      window_result_t want;
      windows_seen++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result low_ms %0d low_percent %0d particle_count %0d",
                 $time, got.low_ms, got.low_percent, got.particle_count);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.low_ms !== want.low_ms) begin
        $display("%0t: low_ms expected %0d actual %0d", $time, want.low_ms, got.low_ms);
        errors++;
      end
      if (got.low_percent !== want.low_percent) begin
        $display("%0t: low_percent expected %0d actual %0d",
                 $time, want.low_percent, got.low_percent);
        errors++;
      end
      if (got.particle_count !== want.particle_count) begin
        $display("%0t: particle_count expected %0d actual %0d",
                 $time, want.particle_count, got.particle_count);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_wdata;

  dslom_in_if  tick_ch ();
  dslom_out_if result_ch ();

  occupancy_scoreboard board;

  // Per-phase switches: no idling on a side, and the one long result stall
  bit          src_fast;
  bit          snk_fast;
  bit          long_hold;
  int unsigned rand_ticks;
  int unsigned cycle_cnt;

  dust_sensor_low_occupancy_meter #(
    .PERCENT_FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_ch_i    (tick_ch),
    .out_ch_o   (result_ch)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Offer one tick after a random gap and hold it until the meter takes it.
  // Valid stays high on return, so back-to-back ticks keep valid asserted between them.
  task automatic send_tick(input logic pin);
    int unsigned gap;
    gap = src_fast ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.pin_low <= pin;
    do @(posedge clk_i); while (!tick_ch.ready);
    board.take_tick(pin);
    @(negedge clk_i);
  endtask

  // Send n ticks, LSB first
  task automatic send_bits(input logic [31:0] bits, input int unsigned n);
    for (int unsigned k = 0; k < n; k++) send_tick(bits[k]);
  endtask

  // Drop valid, let every owed result drain and the last tick settle, then
  // write the window register for one cycle
  task automatic program_window(input logic [WIN_W-1:0] value);
    tick_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    board.set_window(value);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Result side: random ready gaps, plus the long stall when requested
  initial begin : result_sink
    int unsigned    gap;
    window_result_t got;
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        for (int unsigned k = 0; k < HOLD_CYCLES; k++) @(negedge clk_i);
        long_hold = 1'b0;
      end
      gap = snk_fast ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
      got.low_ms         = result_ch.low_ms;
      got.low_percent    = result_ch.low_percent;
      got.particle_count = result_ch.particle_count;
      board.match_result(got);
      @(negedge clk_i);
    end
  end

  // Cycle counter: end the run if the meter hangs
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("dust_sensor_low_occupancy_meter test failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick, n, density, mode;
    logic [WIN_W-1:0] win;
    logic pin;

    board           = new();
    src_fast        = 1'b0;
    snk_fast        = 1'b0;
    long_hold       = 1'b0;
    rand_ticks      = 0;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    tick_ch.valid   = 1'b0;
    tick_ch.pin_low = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part
    // reset window of 30000: partial count only
    send_bits(32'b011, 3);
    // widest window, still partial
    program_window(16'hFFFF);
    send_bits(32'b01, 2);
    // shrink below the ticks counted: closes at once, lows exceed window
    program_window(16'd2);
    send_bits(32'b1, 1);
    // zero window acts as one: every tick closes, full and empty
    program_window(16'd0);
    send_bits(32'b01, 2);
    program_window(16'd1);
    send_bits(32'b1, 1);
    // short window, fractional percentage
    program_window(16'd3);
    send_bits(32'b110, 3);
    // exactly one hundred percent, then exactly zero
    program_window(16'd7);
    send_bits(32'h7F, 7);
    program_window(16'd6);
    send_bits(32'h00, 6);

    // Pressure: one result per tick while the sink holds off, so the output
    // register fills, the next window end waits and tick ready drops
    program_window(16'd1);
    src_fast  = 1'b1;
    long_hold = 1'b1;
    for (int unsigned k = 0; k < 12; k++) send_tick(1'($urandom_range(0, 1)));
    src_fast = 1'b0;

    // Random phases: a window, a burst of ticks with a chosen low density
    while (rand_ticks < RAND_ITEMS || board.windows_seen < MIN_WINDOWS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        win = 16'd0;
      end else if (pick < 15) begin
        win = 16'd1;
      end else if (pick < 55) begin
        win = WIN_W'($urandom_range(2, 40));
      end else if (pick < 80) begin
        win = WIN_W'($urandom_range(41, 120));
      end else if (pick < 92) begin
        win = WIN_W'($urandom_range(100, 300));
      end else begin
        win = 16'hFFFF;
      end
      program_window(win);

      if (win == 16'hFFFF) begin
        n = $urandom_range(1, 50);
      end else begin
        n = $urandom_range(1, 2 * ((win == 0) ? 1 : win) + 2);
        if (n > 400) n = 400;
      end
      mode     = $urandom_range(0, 5);
      density  = $urandom_range(0, 100);
      src_fast = ($urandom_range(0, 3) == 0);
      snk_fast = ($urandom_range(0, 3) == 0);

      for (int unsigned k = 0; k < n; k++) begin
        case (mode)
          0: begin
            pin = 1'b0;
          end
          1: begin
            pin = 1'b1;
          end
          default: begin
            pin = ($urandom_range(0, 99) < density);
          end
        endcase
        send_tick(pin);
        rand_ticks++;
      end
    end

    // Drain: wait for every owed result, then let any stray one show up
    tick_ch.valid <= 1'b0;
    src_fast = 1'b0;
    snk_fast = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("dust_sensor_low_occupancy_meter test passed");
    end else begin
      $display("dust_sensor_low_occupancy_meter test failed");
    end
    $finish;
  end

endmodule
